>>> rtl/kcs_pkg.sv
package kcs_pkg;

  // table geometry and field widths
  localparam int MAX_KEYS = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int TIME_W   = 17;
  localparam int VAL_W    = 32;
  localparam int LANES    = 3;

  // interpolation datapath widths
  localparam int DIFF_W = VAL_W + 1;           // v1 - v0
  localparam int MAG_W  = TIME_W + VAL_W;      // |dt * (v1 - v0)| <= 2^48
  localparam int QUO_W  = VAL_W + 1;           // quotient never exceeds |v1 - v0|
  localparam int PROD_W = 2 * VAL_W;           // value times scale

  // stream payload widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 104;

  localparam logic [TIME_W-1:0] TIME_ONE = 17'h10000;
  localparam logic [CNT_W-1:0]  MIN_KEYS = 7'd2;

  // configuration register indexes, selected by paddr[2]
  localparam logic REG_KEY_COUNT = 1'b0;
  localparam logic REG_DIMS      = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BEYOND = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  // input kind carried on tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       cap;          // capture sample time and scale, seed the search index
    logic       wr;           // write one key into the tables
    logic       restart;      // search index back to key 0
    logic [1:0] raddr_off;    // time table read at index plus offset
    logic       tc_load;      // hold the time read as the segment start
    logic       c_inc;        // advance the search index
    logic       cursor_load;  // keep the search index for the next sample
    logic       seg_load;     // latch time offset and segment span
    logic       set_st;
    status_t    st;
    logic       vaddr_off;    // value tables read at index plus offset
    logic       v0_load;
    logic       v1_load;
    logic       mul_load;
    logic       div_start;
    logic       add_load;
    logic       scale_load;
    logic       out_load;
  } kcs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mode;       // kind of the item on offer
    logic t_big;      // offered sample time above 1.0
    logic tc_gt;      // time read lies after the sample time
    logic c_zero;     // search index is key 0
    logic t_gt_dn;    // sample time lies after the time read
    logic c_last;     // search index is at the last segment
    logic dn_eq_tc;   // next key time equals segment start
    logic div_done;
    logic out_free;
  } kcs_sts_t;

endpackage

>>> rtl/keyframe_curve_sampler_unit.sv
// a sample time above 1.0 goes straight to the result with range status; others search from
// the stored index, back at key 0 if the first time read lies after the sample time, and end
// with range, beyond or zero-length status, or go on through value reads, multiply, divide
// (which takes most of the time), add and scale; a load is written at acceptance, no result
// one sample at a time: the next item is taken once the result is in the output register
// synchronous reset: key_count 2, dimensions 0, cursor 0; key tables are not cleared
module keyframe_curve_sampler_unit import kcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // key_index, key_time, key_value_x, key_value_y, key_value_z, sample_time, scale
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode
  input  logic                  s_tuser,
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // value_x, value_y, value_z, segment, status
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] key_count;
  logic             dimensions;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_m2;
  logic             cfg_wr;
  kcs_cmd_t         cmd;
  kcs_sts_t         sts;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count  <= MIN_KEYS;
      dimensions <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_KEY_COUNT: key_count  <= pwdata[CNT_W-1:0];
        REG_DIMS:      dimensions <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KEY_COUNT: prdata = {{(32-CNT_W){1'b0}}, key_count};
      REG_DIMS:      prdata = {31'b0, dimensions};
      default:       prdata = '0;
    endcase
  end

  // key count used clamped to the table
  always_comb begin
    if (key_count < MIN_KEYS) begin
      n_eff = MIN_KEYS;
    end else if (key_count > CNT_W'(MAX_KEYS)) begin
      n_eff = CNT_W'(MAX_KEYS);
    end else begin
      n_eff = key_count;
    end
  end

  assign n_m2 = n_eff - MIN_KEYS;

  kcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kcs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .n_m2     (n_m2),
    .dims     (dimensions),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/kcs_ram.sv
module kcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kcs_div.sv
module kcs_div import kcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [MAG_W-1:0]      num,
  input  logic [TIME_W-1:0]     den,
  output logic [QUO_W-1:0]      quo,
  output logic                  done
);

  localparam int CW = $clog2(QUO_W);
  localparam logic [CW-1:0] LAST = CW'(QUO_W - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [TIME_W-1:0] rem;
  logic [QUO_W-1:0]  sh;
  logic [TIME_W:0]   trial;
  logic              fits;

  // restoring division, one quotient bit a cycle; the top bits of the
  // dividend are already below the divisor, so they seed the remainder
  assign trial = {rem, sh[QUO_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= TIME_W'(num[MAG_W-1:QUO_W]);
      sh  <= num[QUO_W-1:0];
    end else if (busy) begin
      rem <= fits ? TIME_W'(trial - {1'b0, den}) : trial[TIME_W-1:0];
      sh  <= {sh[QUO_W-2:0], fits};
    end
  end

endmodule

>>> rtl/kcs_ctrl.sv
module kcs_ctrl import kcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  kcs_sts_t sts,
  output kcs_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SEEK   = 14'b00000000000010,
    S_CHECK  = 14'b00000000000100,
    S_WALK   = 14'b00000000001000,
    S_VREAD0 = 14'b00000000010000,
    S_VREAD1 = 14'b00000000100000,
    S_VREAD2 = 14'b00000001000000,
    S_MULT   = 14'b00000010000000,
    S_DSTART = 14'b00000100000000,
    S_DIVIDE = 14'b00001000000000,
    S_ADDV   = 14'b00010000000000,
    S_SCALE  = 14'b00100000000000,
    S_RESULT = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // sequencing of search, interpolation and result
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (sts.mode == MODE_LOAD) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.cap = 1'b1;
            if (sts.t_big) begin
              cmd.restart = 1'b1;
              cmd.set_st  = 1'b1;
              cmd.st      = ST_RANGE;
              state_next  = S_RESULT;
            end else begin
              state_next = S_SEEK;
            end
          end
        end
      end
      S_SEEK: begin
        cmd.raddr_off = 2'd0;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.tc_gt) begin
          if (sts.c_zero) begin
            cmd.set_st      = 1'b1;
            cmd.st          = ST_RANGE;
            cmd.cursor_load = 1'b1;
            state_next      = S_RESULT;
          end else begin
            cmd.restart = 1'b1;
          end
        end else begin
          cmd.tc_load   = 1'b1;
          cmd.raddr_off = 2'd1;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.t_gt_dn) begin
          if (sts.c_last) begin
            cmd.set_st      = 1'b1;
            cmd.st          = ST_BEYOND;
            cmd.cursor_load = 1'b1;
            state_next      = S_RESULT;
          end else begin
            cmd.c_inc     = 1'b1;
            cmd.tc_load   = 1'b1;
            cmd.raddr_off = 2'd2;
          end
        end else if (sts.dn_eq_tc) begin
          cmd.set_st      = 1'b1;
          cmd.st          = ST_ZERO;
          cmd.cursor_load = 1'b1;
          state_next      = S_RESULT;
        end else begin
          cmd.cursor_load = 1'b1;
          cmd.seg_load    = 1'b1;
          state_next      = S_VREAD0;
        end
      end
      S_VREAD0: begin
        cmd.vaddr_off = 1'b0;
        state_next    = S_VREAD1;
      end
      S_VREAD1: begin
        cmd.vaddr_off = 1'b1;
        cmd.v0_load   = 1'b1;
        state_next    = S_VREAD2;
      end
      S_VREAD2: begin
        cmd.v1_load = 1'b1;
        state_next  = S_MULT;
      end
      S_MULT: begin
        cmd.mul_load = 1'b1;
        state_next   = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (sts.div_done) begin
          state_next = S_ADDV;
        end
      end
      S_ADDV: begin
        cmd.add_load = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_load = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/kcs_datapath.sv
module kcs_datapath import kcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic [CNT_W-1:0]      n_m2,
  input  logic                  dims,
  input  kcs_cmd_t              cmd,
  output kcs_sts_t              sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // saturate value times scale, shifted right by 16, to signed 32 bits
  function automatic logic [VAL_W-1:0] sat_shift(input logic [PROD_W-1:0] p);
    logic [VAL_W-1:0] r;
    if ((p[PROD_W-1:47] == '0) || (p[PROD_W-1:47] == '1)) begin
      r = p[47:16];
    end else if (p[PROD_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  // input fields
  logic [IDX_W-1:0]  in_idx;
  logic [TIME_W-1:0] in_ktime;
  logic [VAL_W-1:0]  in_val [LANES];
  logic [TIME_W-1:0] in_stime;
  logic [VAL_W-1:0]  in_scale;

  assign in_idx    = s_tdata[5:0];
  assign in_ktime  = s_tdata[22:6];
  assign in_val[0] = s_tdata[54:23];
  assign in_val[1] = s_tdata[86:55];
  assign in_val[2] = s_tdata[118:87];
  assign in_stime  = s_tdata[135:119];
  assign in_scale  = s_tdata[167:136];

  // search and segment registers
  logic [TIME_W-1:0] t_q;
  logic [VAL_W-1:0]  s_q;
  logic [IDX_W-1:0]  c;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  seed;
  logic [TIME_W-1:0] tc;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] span;
  status_t           status;

  // key time table
  logic [IDX_W-1:0]  raddr;
  logic [TIME_W-1:0] t_rd;

  assign raddr = cmd.restart ? '0 : IDX_W'(c + IDX_W'(cmd.raddr_off));

  kcs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_times (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (in_idx),
    .wdata (in_ktime),
    .raddr (raddr),
    .rdata (t_rd)
  );

  // the stored index restarts at key 0 when it lies past the last segment
  assign seed = ({1'b0, cursor} > n_m2) ? '0 : cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.cursor_load) begin
      cursor <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      t_q <= in_stime;
      s_q <= in_scale;
    end
    // an error found at capture overrides the fresh ok status
    if (cmd.set_st) begin
      status <= cmd.st;
    end else if (cmd.cap) begin
      status <= ST_OK;
    end
    if (cmd.restart) begin
      c <= '0;
    end else if (cmd.cap) begin
      c <= seed;
    end else if (cmd.c_inc) begin
      c <= c + IDX_W'(1);
    end
    if (cmd.tc_load) begin
      tc <= t_rd;
    end
    if (cmd.seg_load) begin
      dt   <= t_q - tc;
      span <= t_rd - tc;
    end
  end

  // value lanes: read, difference, multiply, divide, add, scale
  logic [IDX_W-1:0]         vaddr;
  logic [VAL_W-1:0]         v_rd   [LANES];
  logic [VAL_W-1:0]         v0     [LANES];
  logic [VAL_W-1:0]         v1     [LANES];
  logic [MAG_W-1:0]         mag    [LANES];
  logic                     neg    [LANES];
  logic [QUO_W-1:0]         quo    [LANES];
  logic                     done   [LANES];
  logic signed [VAL_W-1:0]  vsum   [LANES];
  logic signed [PROD_W-1:0] prod   [LANES];
  logic [VAL_W-1:0]         res    [LANES];

  assign vaddr = IDX_W'(c + IDX_W'(cmd.vaddr_off));

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [DIFF_W-1:0]          diff;
    logic [DIFF_W-1:0]          absd;
    logic [MAG_W-1:0]           full;
    logic [QUO_W:0]             qs;
    logic [QUO_W:0]             sum;

    kcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_vals (
      .clk   (clk),
      .we    (cmd.wr),
      .waddr (in_idx),
      .wdata (in_val[j]),
      .raddr (vaddr),
      .rdata (v_rd[j])
    );

    kcs_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (cmd.div_start),
      .num   (mag[j]),
      .den   (span),
      .quo   (quo[j]),
      .done  (done[j])
    );

    // sign and magnitude of the value step
    assign diff = {v1[j][VAL_W-1], v1[j]} - {v0[j][VAL_W-1], v0[j]};
    assign absd = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
    assign full = MAG_W'(dt) * MAG_W'(absd);

    // quotient back to signed, added to the segment start
    assign qs  = neg[j] ? (QUO_W+1)'(-{1'b0, quo[j]}) : {1'b0, quo[j]};
    assign sum = {{2{v0[j][VAL_W-1]}}, v0[j]} + qs;

    always_ff @(posedge clk) begin
      if (cmd.v0_load) begin
        v0[j] <= v_rd[j];
      end
      if (cmd.v1_load) begin
        v1[j] <= v_rd[j];
      end
      if (cmd.mul_load) begin
        mag[j] <= full;
        neg[j] <= diff[DIFF_W-1];
      end
      if (cmd.add_load) begin
        vsum[j] <= sum[VAL_W-1:0];
      end
      if (cmd.scale_load) begin
        prod[j] <= vsum[j] * $signed(s_q);
      end
    end

    // zero on any error, and for the second and third value in one-value mode
    assign res[j] = ((status == ST_OK) && ((j == 0) || dims)) ? sat_shift(prod[j]) : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {status, c, res[2], res[1], res[0]};
    end
  end

  // status towards the controller
  always_comb begin
    sts          = '0;
    sts.mode     = s_tuser;
    sts.t_big    = in_stime > TIME_ONE;
    sts.tc_gt    = t_rd > t_q;
    sts.c_zero   = (c == '0);
    sts.t_gt_dn  = t_q > t_rd;
    sts.c_last   = {1'b0, c} >= n_m2;
    sts.dn_eq_tc = (t_rd == tc);
    sts.div_done = done[0] && done[1] && done[2];
    sts.out_free = !m_tvalid || m_tready;
  end

endmodule
